@@ sv/sse_pkg.sv @@
// Shared types, codes and constants for the sprite scanline evaluator.
// No dependencies; imported by every module of the block.
package sse_pkg;

	localparam int NUM_ENTRIES_DEF  = 64;
	localparam int MAX_SELECTED_DEF = 8;

	localparam int STORE_BYTES = 256;
	localparam int ROW_W       = 6;     // 64 rows of 4 bytes
	localparam int PTR_W       = 8;
	localparam int LINE_W      = 10;
	localparam int PADDR_W     = 13;
	localparam int COUNT_W     = 4;

	// configuration register indexes
	localparam logic CFG_TALL     = 1'b0;
	localparam logic CFG_TBL_HIGH = 1'b1;

	typedef enum logic [1:0] {
		REQ_SET   = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_EVAL  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_SPRITE  = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_READ    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_SUM
	} state_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           read_byte;
		logic [2:0]           slot;
		logic [7:0]           sprite_x;
		logic [7:0]           sprite_attr;
		logic [7:0]           sprite_tile;
		logic [PADDR_W-1:0]   pattern_addr;
		logic                 is_first_entry;
		logic [COUNT_W-1:0]   found_count;
		logic                 overflow;
		logic                 zero_selected;
		logic                 last;
	} res_t;

	// Low-plane row address; row is the low bits of scanline - Y.
	function automatic logic [PADDR_W-1:0] pattern_row_addr(
		input logic [7:0] tile,
		input logic [7:0] attr,
		input logic [3:0] row,
		input logic       tall,
		input logic       tbl_high
	);
		logic [3:0] r;
		logic [PADDR_W-1:0] a;
		r = attr[7] ? ~row : row;
		if (tall) begin
			a = {tile[0], tile[7:1], r[3], 1'b0, r[2:0]};
		end else begin
			a = {tbl_high, tile, 1'b0, r[2:0]};
		end
		return a;
	endfunction

endpackage

@@ sv/sse_store.sv @@
// Attribute store: 64 rows of four bytes, byte-wide writes, one row read per cycle.
// Per-byte valid bits make unwritten bytes read as 0xFF after reset. Uses sse_pkg.
module sse_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [sse_pkg::PTR_W-1:0] wr_ptr,
	input  logic [7:0]                wr_data,
	input  logic [sse_pkg::ROW_W-1:0] rd_row,
	output logic [31:0]               rd_data
);
	import sse_pkg::*;

	logic [31:0]            mem [2**ROW_W];
	logic [STORE_BYTES-1:0] vld_q;
	logic [31:0]            rd_s1;
	logic [3:0]             vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_ptr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr[PTR_W-1:2]][{wr_ptr[1:0], 3'b000} +: 8] <= wr_data;
		end
		rd_s1  <= mem[rd_row];
		vld_s1 <= vld_q[{rd_row, 2'b00} +: 4];
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rd_data[k*8 +: 8] = vld_s1[k] ? rd_s1[k*8 +: 8] : 8'hFF;
		end
	end

endmodule

@@ sv/sse_ctrl.sv @@
// Request sequencer: store pointer, read and scanline scan over the store rows.
// Drives the store ports and hands results to the output register. Uses sse_pkg.
module sse_ctrl #(
	parameter int NUM_ENTRIES  = sse_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_SELECTED = sse_pkg::MAX_SELECTED_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sse_pkg::req_t              in_req,
	input  logic [7:0]                 in_data,
	input  logic [sse_pkg::LINE_W-1:0] in_line,
	input  logic                       tall,
	input  logic                       tbl_high,
	output logic                       wr_en,
	output logic [sse_pkg::PTR_W-1:0]  wr_ptr,
	output logic [7:0]                 wr_data,
	output logic [sse_pkg::ROW_W-1:0]  rd_row,
	input  logic [31:0]                rd_data,
	output logic                       res_valid,
	output sse_pkg::res_t              res,
	input  logic                       res_ready
);
	import sse_pkg::*;

	localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(NUM_ENTRIES - 1);
	localparam logic [COUNT_W-1:0] MAX_SEL  = COUNT_W'(MAX_SELECTED);

	state_t              state_q, state_d;
	logic [PTR_W-1:0]    ptr_q;
	logic [LINE_W-1:0]   line_q;
	logic [ROW_W-1:0]    cnt_q;
	logic [COUNT_W-1:0]  found_q;
	logic                over_q, zero_q;

	logic [7:0]          y_b, tile_b, attr_b, x_b;
	logic [LINE_W:0]     diff;
	logic                match, room, emit, step;

	assign y_b    = rd_data[7:0];
	assign tile_b = rd_data[15:8];
	assign attr_b = rd_data[23:16];
	assign x_b    = rd_data[31:24];

	// scanline - Y as 11-bit two's complement
	assign diff  = {line_q[LINE_W-1], line_q} - {3'b000, y_b};
	assign match = !diff[LINE_W] && (tall ? (diff[LINE_W-1:4] == '0) : (diff[LINE_W-1:3] == '0));
	assign room  = found_q < MAX_SEL;
	assign emit  = match && room;

	assign wr_ptr  = ptr_q;
	assign wr_data = in_data;

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		step      = 1'b0;
		rd_row    = ptr_q[PTR_W-1:2];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				wr_en    = in_valid && (in_req == REQ_WRITE);
				rd_row   = (in_req == REQ_EVAL) ? '0 : ptr_q[PTR_W-1:2];
			end
			ST_READ: begin
				res_valid     = 1'b1;
				res.kind      = KIND_READ;
				res.read_byte = rd_data[{ptr_q[1:0], 3'b000} +: 8];
				res.last      = 1'b1;
			end
			ST_EVAL: begin
				res_valid          = emit;
				res.kind           = KIND_SPRITE;
				res.slot           = found_q[2:0];
				res.sprite_x       = x_b;
				res.sprite_attr    = attr_b;
				res.sprite_tile    = tile_b;
				res.pattern_addr   = pattern_row_addr(tile_b, attr_b, diff[3:0], tall, tbl_high);
				res.is_first_entry = (cnt_q == '0);
				step               = !emit || res_ready;
				// on a stall the same row is read again so the data holds
				rd_row             = step ? cnt_q + 1'b1 : cnt_q;
			end
			ST_SUM: begin
				res_valid         = 1'b1;
				res.kind          = KIND_SUMMARY;
				res.found_count   = found_q;
				res.overflow      = over_q;
				res.zero_selected = zero_q;
				res.last          = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_req == REQ_READ) state_d = ST_READ;
				if (in_valid && in_req == REQ_EVAL) state_d = ST_EVAL;
			end
			ST_READ: if (res_ready) state_d = ST_IDLE;
			ST_EVAL: if (step && cnt_q == LAST_ROW) state_d = ST_SUM;
			ST_SUM:  if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			cnt_q   <= '0;
			found_q <= '0;
			over_q  <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q   <= '0;
				found_q <= '0;
				over_q  <= 1'b0;
				zero_q  <= 1'b0;
				if (in_valid && in_req == REQ_SET)   ptr_q <= in_data;
				if (in_valid && in_req == REQ_WRITE) ptr_q <= ptr_q + 1'b1;
			end else if (state_q == ST_EVAL && step) begin
				cnt_q <= cnt_q + 1'b1;
				if (emit) begin
					found_q <= found_q + 1'b1;
					if (cnt_q == '0) zero_q <= 1'b1;
				end
				if (match && !room) over_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) line_q <= in_line;
	end

endmodule

@@ sv/sse_obuf.sv @@
// Output register between the sequencer and the master-side stream.
// Takes a new word while the held one drains. Uses sse_pkg.
module sse_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  sse_pkg::res_t res,
	output logic          res_ready,
	output logic          out_valid,
	output sse_pkg::res_t out_res,
	input  logic          out_ready
);
	import sse_pkg::*;

	logic valid_q;
	res_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) res_q <= res;
	end

endmodule

@@ sv/sprite_scanline_evaluator.sv @@
// Sprite scanline evaluator: 256-byte attribute store (0xFF after reset) plus pointer.
// A read word can be held by output back-pressure. An evaluate word scans the store
// one four-byte entry per cycle from its single read port while the output side keeps
// up; each selected sprite holds the scan until the output register is free. Results
// leave as words with tuser = kind and tlast on the final one.
// Depends on sse_pkg, sse_store, sse_ctrl, sse_obuf.
module sprite_scanline_evaluator #(
	parameter int NUM_ENTRIES  = sse_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_SELECTED = sse_pkg::MAX_SELECTED_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // data_byte[7:0], scanline[17:8], zero pad
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // read_byte, slot, sprite_x, sprite_attr,
	                                    // sprite_tile, pattern_addr, is_first_entry,
	                                    // found_count, overflow, zero_selected, pad
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	import sse_pkg::*;

	logic                tall_q, tbl_high_q;
	logic                wr_en;
	logic [PTR_W-1:0]    wr_ptr;
	logic [7:0]          wr_data;
	logic [ROW_W-1:0]    rd_row;
	logic [31:0]         rd_data;
	logic                res_valid, res_ready;
	res_t                res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q     <= 1'b0;
			tbl_high_q <= 1'b0;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_TALL)     tall_q     <= cfg_data;
			if (cfg_index == CFG_TBL_HIGH) tbl_high_q <= cfg_data;
		end
	end

	sse_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_ptr  (wr_ptr),
		.wr_data (wr_data),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	sse_ctrl #(
		.NUM_ENTRIES  (NUM_ENTRIES),
		.MAX_SELECTED (MAX_SELECTED)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (req_t'(s_axis_tuser)),
		.in_data   (s_axis_tdata[7:0]),
		.in_line   (s_axis_tdata[17:8]),
		.tall      (tall_q),
		.tbl_high  (tbl_high_q),
		.wr_en     (wr_en),
		.wr_ptr    (wr_ptr),
		.wr_data   (wr_data),
		.rd_row    (rd_row),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	sse_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;
	assign m_axis_tdata = {1'b0,
		out_res.zero_selected,
		out_res.overflow,
		out_res.found_count,
		out_res.is_first_entry,
		out_res.pattern_addr,
		out_res.sprite_tile,
		out_res.sprite_attr,
		out_res.sprite_x,
		out_res.slot,
		out_res.read_byte};

endmodule

@@ tb/sv/tb_sprite_scanline_evaluator.sv @@
// Self-checking testbench for sprite_scanline_evaluator: request words go in through a
// queue-fed driver, a shadow attribute store predicts each output word in order.
// Depends on sse_pkg and the sprite_scanline_evaluator RTL.
module tb_sprite_scanline_evaluator;
	timeunit 1ns;
	timeprecision 1ps;
	import sse_pkg::*;

	localparam int   LIMIT_CYCLES = 1_000_000;
	localparam int   DRAIN_CYCLES = 100;
	localparam int   PHASES       = 5;
	localparam int   PHASE_ITEMS  = 66;
	// per-phase register settings, bit p for phase p
	localparam bit [PHASES-1:0] TALL_BY_PHASE = 5'b01100;
	localparam bit [PHASES-1:0] HIGH_BY_PHASE = 5'b01010;

	typedef struct packed {
		req_t       req;
		logic [7:0] data;
		logic [9:0] line;
	} request_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_index     = 1'b0;
	logic        cfg_data      = 1'b0;

	// shadow of the block state
	logic [7:0] oam_shadow [256];
	logic [7:0] oam_ptr;
	logic       shadow_tall;
	logic       shadow_tbl_high;

	request_t pending_requests[$];
	res_t     expected_words[$];
	request_t in_flight;
	int       tx_gap      = 0;
	int       rx_stall    = 0;
	int       failures    = 0;
	int       cycle_count = 0;
	bit       no_idle     = 1'b0;

	sprite_scanline_evaluator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [12:0] sprite_row_addr(logic [7:0] tile, logic [7:0] attr,
			int diff);
		int         row;
		logic [7:0] t;
		row = diff;
		if (!shadow_tall) begin
			if (attr[7]) row = 7 - row;
			return (shadow_tbl_high ? 13'h1000 : 13'h0000) | (13'(tile) << 4) | 13'(row & 7);
		end
		t = tile & 8'hFE;
		if (attr[7]) row = 15 - row;
		row = row & 15;
		if (row >= 8) begin
			t = t + 8'd1;
			row = row - 8;
		end
		return (13'(tile[0]) << 12) | (13'(t) << 4) | 13'(row);
	endfunction

	// Applies one accepted request to the shadow state and queues its output words.
	function automatic void predict_request(request_t rq);
		res_t       r;
		int         ln, diff, found, height;
		logic       over, zero;
		logic [7:0] tile, attr;
		ln = $signed(rq.line);
		case (rq.req)
			REQ_SET: oam_ptr = rq.data;
			REQ_WRITE: begin
				oam_shadow[oam_ptr] = rq.data;
				oam_ptr = oam_ptr + 8'd1;
			end
			REQ_READ: begin
				r = '0;
				r.kind = KIND_READ;
				r.read_byte = oam_shadow[oam_ptr];
				r.last = 1'b1;
				expected_words.push_back(r);
			end
			default: begin
				found = 0;
				over = 1'b0;
				zero = 1'b0;
				height = shadow_tall ? 16 : 8;
				for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
					diff = ln - int'(oam_shadow[i*4]);
					if (diff >= 0 && diff < height) begin
						if (found < MAX_SELECTED_DEF) begin
							tile = oam_shadow[i*4+1];
							attr = oam_shadow[i*4+2];
							r = '0;
							r.kind = KIND_SPRITE;
							r.slot = 3'(found);
							r.sprite_x = oam_shadow[i*4+3];
							r.sprite_attr = attr;
							r.sprite_tile = tile;
							r.pattern_addr = sprite_row_addr(tile, attr, diff);
							r.is_first_entry = (i == 0);
							if (i == 0) zero = 1'b1;
							found++;
							expected_words.push_back(r);
						end else begin
							over = 1'b1;
						end
					end
				end
				r = '0;
				r.kind = KIND_SUMMARY;
				r.found_count = 4'(found);
				r.overflow = over;
				r.zero_selected = zero;
				r.last = 1'b1;
				expected_words.push_back(r);
			end
		endcase
	endfunction

	function automatic string fmt_word(res_t w);
		return $sformatf({"kind=%0d rd=%h slot=%0d x=%h attr=%h tile=%h paddr=%h ",
			"first=%b cnt=%0d ovf=%b zero=%b last=%b"}, w.kind, w.read_byte, w.slot,
			w.sprite_x, w.sprite_attr, w.sprite_tile, w.pattern_addr, w.is_first_entry,
			w.found_count, w.overflow, w.zero_selected, w.last);
	endfunction

	function automatic void log_failure(string msg);
		failures++;
		if (failures <= 10) $display("mismatch @%0t: %s", $realtime, msg);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_request(in_flight);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0 || pending_requests.size() == 0) begin
					if (tx_gap > 0) tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else begin
					in_flight = pending_requests.pop_front();
					s_axis_tuser <= in_flight.req;
					s_axis_tdata <= {6'd0, in_flight.line, in_flight.data};
					s_axis_tvalid <= 1'b1;
					tx_gap = idle_len();
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		res_t  got, want;
		string bad;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind           = kind_t'(m_axis_tuser);
				got.read_byte      = m_axis_tdata[7:0];
				got.slot           = m_axis_tdata[10:8];
				got.sprite_x       = m_axis_tdata[18:11];
				got.sprite_attr    = m_axis_tdata[26:19];
				got.sprite_tile    = m_axis_tdata[34:27];
				got.pattern_addr   = m_axis_tdata[47:35];
				got.is_first_entry = m_axis_tdata[48];
				got.found_count    = m_axis_tdata[52:49];
				got.overflow       = m_axis_tdata[53];
				got.zero_selected  = m_axis_tdata[54];
				got.last           = m_axis_tlast;
				if (expected_words.size() == 0) begin
					log_failure({"word with nothing expected: ", fmt_word(got)});
				end else begin
					want = expected_words.pop_front();
					bad = "";
					if (got.kind !== want.kind) bad = {bad, " kind"};
					if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
					if (got.slot !== want.slot) bad = {bad, " slot"};
					if (got.sprite_x !== want.sprite_x) bad = {bad, " sprite_x"};
					if (got.sprite_attr !== want.sprite_attr) bad = {bad, " sprite_attr"};
					if (got.sprite_tile !== want.sprite_tile) bad = {bad, " sprite_tile"};
					if (got.pattern_addr !== want.pattern_addr) bad = {bad, " pattern_addr"};
					if (got.is_first_entry !== want.is_first_entry) bad = {bad, " first"};
					if (got.found_count !== want.found_count) bad = {bad, " found_count"};
					if (got.overflow !== want.overflow) bad = {bad, " overflow"};
					if (got.zero_selected !== want.zero_selected) bad = {bad, " zero_sel"};
					if (got.last !== want.last) bad = {bad, " last"};
					if (bad != "")
						log_failure({"field(s)", bad, "\n  exp ", fmt_word(want),
							"\n  got ", fmt_word(got)});
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[sprite_scanline_evaluator] ERROR");
			$finish;
		end
	end

	function automatic void add(req_t req, logic [7:0] data, int line);
		request_t rq;
		rq.req = req;
		rq.data = data;
		rq.line = 10'(line);
		pending_requests.push_back(rq);
	endfunction

	function automatic int junk_line();
		return $urandom_range(0, 1023);
	endfunction

	// one four-byte entry: Y, tile, attr, X; Y mostly lands on or just above the focus line
	function automatic void add_entry(int focus);
		int y;
		y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : focus - $urandom_range(0, 15);
		if (y < 0) y = 0;
		add(REQ_WRITE, 8'(y), junk_line());
		add(REQ_WRITE, 8'($urandom_range(0, 255)), junk_line());
		add(REQ_WRITE, 8'($urandom_range(0, 255)), junk_line());
		add(REQ_WRITE, 8'($urandom_range(0, 255)), junk_line());
	endfunction

	task automatic fill_phase(int n_items);
		int focus, queued, r, entry, cnt, ln;
		focus = $urandom_range(0, 240);
		queued = 0;
		while (queued < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				// crowd a run of entries onto the focus line to reach overflow
				entry = $urandom_range(0, 1) ? 0 : $urandom_range(0, 54);
				cnt = $urandom_range(6, 11);
				if (entry + cnt > 64) cnt = 64 - entry;
				add(REQ_SET, 8'(entry * 4), junk_line());
				for (int k = 0; k < cnt; k++) add_entry(focus);
				queued += 1 + 4 * cnt;
			end else if (r < 35) begin
				add(REQ_SET, 8'($urandom_range(0, 63) * 4), junk_line());
				add_entry(focus);
				queued += 5;
			end else if (r < 70) begin
				r = $urandom_range(0, 9);
				if (r < 7) ln = focus + $urandom_range(0, 20) - 2;
				else if (r < 9) ln = $urandom_range(0, 1023);
				else ln = $urandom_range(0, 1) ? -1 : $urandom_range(255, 260);
				add(REQ_EVAL, 8'($urandom_range(0, 255)), ln);
				queued++;
			end else if (r < 85) begin
				if ($urandom_range(0, 1)) begin
					add(REQ_SET, 8'($urandom_range(0, 255)), junk_line());
					queued++;
				end
				add(REQ_READ, 8'($urandom_range(0, 255)), junk_line());
				queued++;
			end else begin
				add(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), junk_line());
				queued++;
			end
		end
	endtask

	task automatic write_reg(logic idx, logic val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_TALL) shadow_tall = val;
		else shadow_tbl_high = val;
	endtask

	// set/write words give no result, so allow the block time to finish after the last word
	task automatic wait_idle();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		foreach (oam_shadow[i]) oam_shadow[i] = 8'hFF;
		oam_ptr = '0;
		shadow_tall = 1'b0;
		shadow_tbl_high = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: store content after reset, then a hand-built pair of entries
		add(REQ_READ, 8'h00, 0);
		add(REQ_EVAL, 8'h00, 255);       // every entry matches: overflow, entry zero in
		add(REQ_EVAL, 8'hFF, 260);
		add(REQ_EVAL, 8'h00, -1);        // pre-render line
		add(REQ_SET, 8'h00, 0);
		add(REQ_WRITE, 8'h00, 0);        // entry 0: Y 0, tile FF, vflip, X 0
		add(REQ_WRITE, 8'hFF, 0);
		add(REQ_WRITE, 8'h80, 0);
		add(REQ_WRITE, 8'h00, 0);
		add(REQ_WRITE, 8'h05, 0);        // entry 1: Y 5, hflip
		add(REQ_WRITE, 8'h12, 0);
		add(REQ_WRITE, 8'h43, 0);
		add(REQ_WRITE, 8'hFF, 0);
		add(REQ_EVAL, 8'h00, 0);
		add(REQ_EVAL, 8'h00, 7);
		add(REQ_EVAL, 8'h00, 12);
		add(REQ_EVAL, 8'h00, 511);       // largest positive line
		add(REQ_EVAL, 8'h00, -512);      // most negative line
		add(REQ_SET, 8'hFF, 0);
		add(REQ_WRITE, 8'h77, 1023);     // pointer wraps to zero
		add(REQ_READ, 8'h00, 0);
		add(REQ_SET, 8'hFE, 0);
		add(REQ_READ, 8'hFF, 1023);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_TALL, TALL_BY_PHASE[p]);
			write_reg(CFG_TBL_HIGH, HIGH_BY_PHASE[p]);
			no_idle = (p == 2) || ($urandom_range(0, 4) == 0);
			fill_phase(PHASE_ITEMS);
			wait_idle();
		end

		if (failures == 0 && expected_words.size() == 0) begin
			$display("[sprite_scanline_evaluator] OK");
		end else begin
			$display("[sprite_scanline_evaluator] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sse_pkg.sv
sv/sse_store.sv
sv/sse_ctrl.sv
sv/sse_obuf.sv
sv/sprite_scanline_evaluator.sv
tb/sv/tb_sprite_scanline_evaluator.sv
